### rtl/rlcfs_pkg.sv
// ----------------------------------------------------------------------------
// RLE line-cached frame store package
// Shared constants for the frame store and its memories.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcfs_pkg;

  // Width of one packed RGB888 pixel and of one color channel.
  localparam int COLOR_W = 24;
  localparam int CHAN_W  = 8;

  // Access kinds carried by an input transaction.
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

endpackage

`default_nettype wire

### rtl/rlcfs_ram.sv
// ----------------------------------------------------------------------------
// RLE frame store RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcfs_ram
  import rlcfs_pkg::*;
#(
  parameter int DW    = 24,
  parameter int AW    = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds its value until the next read is issued.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/rle_line_cached_frame_store.sv
// ----------------------------------------------------------------------------
// RLE line-cached frame store
// RGB888 frame kept as run-length encoded lines with a small FIFO line cache.
// ----------------------------------------------------------------------------
// Each input transaction reads or writes one pixel at (pos_x, pos_y). Lines
// live in a run store as (color, length) runs; up to CACHE_LINES lines are
// held decoded in a pixel cache RAM. On a cache hit a write passes through
// lookup and the pixel access before the next transaction can be accepted; a
// read also waits for the registered read of the pixel RAM and then moves its
// result to the output register. A miss with a free slot adds the decode of
// the line: its run count is read, each stored run is read and written out
// pixel by pixel, and the rest of the line is filled with the fill color.
// A miss with a full cache first re-encodes the oldest slot, one pixel read
// per cycle.
// An access outside the frame touches no state; a read outside it returns
// black. The block takes one transaction at a time; a finished read result
// waits in the output register, so the next transaction can be accepted
// while it is stalled. After reset the run count RAM is swept to zero, one
// line per cycle, and no transaction is accepted until the sweep is done.
// The fill_color register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module rle_line_cached_frame_store
  import rlcfs_pkg::*;
#(
  parameter int LINE_WIDTH  = 256,
  parameter int LINE_COUNT  = 256,
  parameter int CACHE_LINES = 4
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // Configuration write channel (fill color).
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [COLOR_W-1:0]  cfg_fill_color,
  // Input transactions.
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                in_kind,
  input  wire logic [CHAN_W-1:0]   in_pos_x,
  input  wire logic [CHAN_W-1:0]   in_pos_y,
  input  wire logic [CHAN_W-1:0]   in_red,
  input  wire logic [CHAN_W-1:0]   in_green,
  input  wire logic [CHAN_W-1:0]   in_blue,
  // Read results.
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [CHAN_W-1:0]        out_red,
  output logic [CHAN_W-1:0]        out_green,
  output logic [CHAN_W-1:0]        out_blue
);

  // Address and counter widths. A single-entry dimension still needs one bit.
  localparam int XW  = (LINE_WIDTH  > 1) ? $clog2(LINE_WIDTH)  : 1;
  localparam int YW  = (LINE_COUNT  > 1) ? $clog2(LINE_COUNT)  : 1;
  localparam int SW  = (CACHE_LINES > 1) ? $clog2(CACHE_LINES) : 1;
  localparam int LW  = $clog2(LINE_WIDTH + 1);   // holds 0..LINE_WIDTH
  localparam int NW  = $clog2(CACHE_LINES + 1);  // holds 0..CACHE_LINES
  localparam int RDW = COLOR_W + LW;             // one run: color and length
  localparam int PIX_DEPTH = CACHE_LINES << XW;
  localparam int RUN_DEPTH = LINE_COUNT << XW;
  localparam int PIX_AW = SW + XW;
  localparam int RUN_AW = YW + XW;
  localparam int POS_W  = 13;                    // wide enough for any range limit

  localparam logic [LW-1:0] LINE_END   = LW'(LINE_WIDTH);
  localparam logic [YW-1:0] LAST_LINE  = YW'(LINE_COUNT - 1);
  localparam logic [NW-1:0] CACHE_FULL = NW'(CACHE_LINES);
  localparam logic [SW-1:0] LAST_SLOT  = SW'(CACHE_LINES - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_ENC,
    ST_DEC_CNT,
    ST_DEC_CNT_W,
    ST_DEC_NEXT,
    ST_DEC_RUN_W,
    ST_DEC_PUT,
    ST_DEC_FILL,
    ST_ACCESS,
    ST_RD_WAIT,
    ST_OUT
  } state_t;

  state_t state_r;

  // Configuration and request registers.
  logic [COLOR_W-1:0] fill_color_r;
  logic               kind_r;
  logic               oob_r;
  logic [XW-1:0]      x_r;
  logic [YW-1:0]      y_r;
  logic [COLOR_W-1:0] wcolor_r;

  // Cache bookkeeping.
  logic [YW-1:0]      tags_r [CACHE_LINES];
  logic [NW-1:0]      lines_cached_r;
  logic [SW-1:0]      oldest_r;
  logic [SW-1:0]      slot_r;
  logic [YW-1:0]      clr_r;

  // Encode and decode sequencing.
  logic [LW-1:0]      cnt_r;
  logic               pend_r;
  logic               first_r;
  logic [COLOR_W-1:0] run_col_r;
  logic [LW-1:0]      run_len_r;
  logic [LW-1:0]      n_r;
  logic [LW-1:0]      nruns_r;
  logic [LW-1:0]      k_r;

  // Output register and pending result.
  logic [COLOR_W-1:0] res_r;
  logic [COLOR_W-1:0] out_pix_r;
  logic               out_valid_r;

  // Memory ports.
  logic               pix_we, pix_re;
  logic [PIX_AW-1:0]  pix_waddr, pix_raddr;
  logic [COLOR_W-1:0] pix_wdata, pix_rdata;
  logic               run_we, run_re;
  logic [RUN_AW-1:0]  run_waddr, run_raddr;
  logic [RDW-1:0]     run_wdata, run_rdata;
  logic               cnt_we, cnt_re;
  logic [YW-1:0]      cnt_waddr, cnt_raddr;
  logic [LW-1:0]      cnt_wdata, cnt_rdata;

  // Incoming position, range check and lookup.
  logic [POS_W-1:0]   px_ext, py_ext;
  logic               hit;
  logic [SW-1:0]      hit_slot;
  logic [YW-1:0]      enc_line;
  logic               enc_issue;
  logic               enc_done;
  logic               enc_break;

  assign px_ext = POS_W'(in_pos_x);
  assign py_ext = POS_W'(in_pos_y);

  // Only the occupied slots take part in the tag compare.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < CACHE_LINES; i++) begin
      if (!hit && (NW'(i) < lines_cached_r) && (tags_r[i] == y_r)) begin
        hit      = 1'b1;
        hit_slot = SW'(i);
      end
    end
  end

  assign enc_line  = tags_r[slot_r];
  assign enc_issue = (state_r == ST_ENC) && (cnt_r != LINE_END);
  assign enc_done  = (state_r == ST_ENC) && (cnt_r == LINE_END) && !pend_r;
  // A pixel arriving with a new color closes the current run.
  assign enc_break = (state_r == ST_ENC) && pend_r && !first_r &&
                     (pix_rdata != run_col_r);

  // Memory control.
  always_comb begin
    pix_we    = 1'b0;
    pix_waddr = {slot_r, x_r};
    pix_wdata = wcolor_r;
    pix_re    = 1'b0;
    pix_raddr = {slot_r, x_r};
    run_we    = 1'b0;
    run_waddr = {enc_line, n_r[XW-1:0]};
    run_wdata = {run_col_r, run_len_r};
    run_re    = 1'b0;
    run_raddr = {y_r, n_r[XW-1:0]};
    cnt_we    = 1'b0;
    cnt_waddr = enc_line;
    cnt_wdata = n_r + LW'(1);
    cnt_re    = 1'b0;
    cnt_raddr = y_r;
    unique case (state_r)
      ST_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
      end
      ST_ENC: begin
        pix_re    = enc_issue;
        pix_raddr = {slot_r, cnt_r[XW-1:0]};
        run_we    = enc_break || enc_done;
        cnt_we    = enc_done;
      end
      ST_DEC_CNT: begin
        cnt_re = 1'b1;
      end
      ST_DEC_NEXT: begin
        run_re = (cnt_r != LINE_END) && (n_r < nruns_r);
      end
      ST_DEC_PUT: begin
        pix_we    = (k_r != '0) && (cnt_r != LINE_END);
        pix_waddr = {slot_r, cnt_r[XW-1:0]};
        pix_wdata = run_col_r;
      end
      ST_DEC_FILL: begin
        pix_we    = (cnt_r != LINE_END);
        pix_waddr = {slot_r, cnt_r[XW-1:0]};
        pix_wdata = fill_color_r;
      end
      ST_ACCESS: begin
        pix_we = (kind_r == KIND_WRITE);
        pix_re = (kind_r == KIND_READ);
      end
      default: begin
      end
    endcase
  end

  rlcfs_ram #(
    .DW    (COLOR_W),
    .AW    (PIX_AW),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .re    (pix_re),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  rlcfs_ram #(
    .DW    (RDW),
    .AW    (RUN_AW),
    .DEPTH (RUN_DEPTH)
  ) u_run_ram (
    .clk   (clk),
    .we    (run_we),
    .waddr (run_waddr),
    .wdata (run_wdata),
    .re    (run_re),
    .raddr (run_raddr),
    .rdata (run_rdata)
  );

  rlcfs_ram #(
    .DW    (LW),
    .AW    (YW),
    .DEPTH (LINE_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  // Configuration is accepted every cycle; the fill color has its own register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_color_r <= '0;
    end else if (cfg_valid) begin
      fill_color_r <= cfg_fill_color;
    end
  end

  // Main sequencer: clear sweep, lookup, eviction encode, line decode, pixel access and result output.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      clr_r          <= '0;
      lines_cached_r <= '0;
      oldest_r       <= '0;
      pend_r         <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      // The output register empties when its transaction is taken, unless a
      // new result is loaded into it in the same cycle.
      if (out_valid_r && !out_stall && (state_r != ST_OUT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_CLEAR: begin
          clr_r <= clr_r + YW'(1);
          if (clr_r == LAST_LINE) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            kind_r   <= in_kind;
            oob_r    <= (px_ext >= POS_W'(LINE_WIDTH)) || (py_ext >= POS_W'(LINE_COUNT));
            x_r      <= px_ext[XW-1:0];
            y_r      <= py_ext[YW-1:0];
            wcolor_r <= {in_red, in_green, in_blue};
            state_r  <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          if (oob_r) begin
            res_r   <= '0;
            state_r <= (kind_r == KIND_READ) ? ST_OUT : ST_IDLE;
          end else if (hit) begin
            slot_r  <= hit_slot;
            state_r <= ST_ACCESS;
          end else if (lines_cached_r == CACHE_FULL) begin
            // Evict the oldest slot: write its pixels back as runs first.
            slot_r   <= oldest_r;
            oldest_r <= (oldest_r == LAST_SLOT) ? '0 : oldest_r + SW'(1);
            cnt_r    <= '0;
            n_r      <= '0;
            first_r  <= 1'b1;
            pend_r   <= 1'b0;
            state_r  <= ST_ENC;
          end else begin
            slot_r         <= SW'(lines_cached_r);
            lines_cached_r <= lines_cached_r + NW'(1);
            state_r        <= ST_DEC_CNT;
          end
        end
        ST_ENC: begin
          pend_r <= enc_issue;
          if (enc_issue) begin
            cnt_r <= cnt_r + LW'(1);
          end
          if (pend_r) begin
            if (first_r) begin
              first_r   <= 1'b0;
              run_col_r <= pix_rdata;
              run_len_r <= LW'(1);
            end else if (enc_break) begin
              n_r       <= n_r + LW'(1);
              run_col_r <= pix_rdata;
              run_len_r <= LW'(1);
            end else begin
              run_len_r <= run_len_r + LW'(1);
            end
          end
          if (enc_done) begin
            state_r <= ST_DEC_CNT;
          end
        end
        ST_DEC_CNT: begin
          tags_r[slot_r] <= y_r;
          state_r        <= ST_DEC_CNT_W;
        end
        ST_DEC_CNT_W: begin
          nruns_r <= (cnt_rdata > LINE_END) ? LINE_END : cnt_rdata;
          n_r     <= '0;
          cnt_r   <= '0;
          state_r <= ST_DEC_NEXT;
        end
        ST_DEC_NEXT: begin
          if (cnt_r == LINE_END) begin
            state_r <= ST_ACCESS;
          end else if (n_r < nruns_r) begin
            n_r     <= n_r + LW'(1);
            state_r <= ST_DEC_RUN_W;
          end else begin
            state_r <= ST_DEC_FILL;
          end
        end
        ST_DEC_RUN_W: begin
          run_col_r <= run_rdata[RDW-1:LW];
          k_r       <= run_rdata[LW-1:0];
          state_r   <= ST_DEC_PUT;
        end
        ST_DEC_PUT: begin
          if ((k_r == '0) || (cnt_r == LINE_END)) begin
            state_r <= ST_DEC_NEXT;
          end else begin
            cnt_r <= cnt_r + LW'(1);
            k_r   <= k_r - LW'(1);
          end
        end
        ST_DEC_FILL: begin
          if (cnt_r == LINE_END) begin
            state_r <= ST_ACCESS;
          end else begin
            cnt_r <= cnt_r + LW'(1);
          end
        end
        ST_ACCESS: begin
          state_r <= (kind_r == KIND_READ) ? ST_RD_WAIT : ST_IDLE;
        end
        ST_RD_WAIT: begin
          res_r   <= pix_rdata;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_pix_r   <= res_r;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r[23:16];
  assign out_green = out_pix_r[15:8];
  assign out_blue  = out_pix_r[7:0];

  // The slot count never exceeds the cache size.
  a_cache_count: assert property (@(posedge clk) disable iff (!rst_n)
    lines_cached_r <= CACHE_FULL)
    else $error("cache slot count exceeds cache size");

  // FIFO eviction only starts once every slot is occupied.
  a_oldest_full: assert property (@(posedge clk) disable iff (!rst_n)
    (oldest_r != '0) |-> (lines_cached_r == CACHE_FULL))
    else $error("eviction pointer moved before cache filled");

  // One transaction at a time: after acceptance the input side stalls.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while busy");

endmodule

`default_nettype wire
